FILE: src/bllca_pkg.sv
// ----------------------------------------------------------------------------
// bllca_pkg
// Shared widths, micro-op codes, branch codes and the microcode ROM of the
// binary-lifting lowest common ancestor block.
// ----------------------------------------------------------------------------
package bllca_pkg;

    localparam int NODE_W          = 10;
    localparam int DEPTH_W         = 10;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 16;
    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 10;

    localparam int UPC_W = 5;
    localparam int OP_W  = 4;
    localparam int BR_W  = 4;

    // micro-ops
    localparam logic [OP_W-1:0] OP_NOP        = 'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 'd1;
    localparam logic [OP_W-1:0] OP_RD_DEP_A   = 'd2;
    localparam logic [OP_W-1:0] OP_RD_DEP_B   = 'd3;
    localparam logic [OP_W-1:0] OP_LD_DA_RD_B = 'd4;
    localparam logic [OP_W-1:0] OP_LD_DB_SWAP = 'd5;
    localparam logic [OP_W-1:0] OP_ATT_BASE   = 'd6;
    localparam logic [OP_W-1:0] OP_RD_ANC     = 'd7;
    localparam logic [OP_W-1:0] OP_ATT_STEP   = 'd8;
    localparam logic [OP_W-1:0] OP_LIFT_A     = 'd9;
    localparam logic [OP_W-1:0] OP_LD_DA      = 'd10;
    localparam logic [OP_W-1:0] OP_SET_K      = 'd11;
    localparam logic [OP_W-1:0] OP_JOINT      = 'd12;
    localparam logic [OP_W-1:0] OP_EMIT       = 'd13;

    // branch kinds
    localparam logic [BR_W-1:0] BR_NEXT     = 'd0;
    localparam logic [BR_W-1:0] BR_JUMP     = 'd1;
    localparam logic [BR_W-1:0] BR_WAIT_IN  = 'd2;
    localparam logic [BR_W-1:0] BR_WAIT_OUT = 'd3;
    localparam logic [BR_W-1:0] BR_KIND_Q   = 'd4;
    localparam logic [BR_W-1:0] BR_A_ZERO   = 'd5;
    localparam logic [BR_W-1:0] BR_ATT_LOOP = 'd6;
    localparam logic [BR_W-1:0] BR_NO_LIFT  = 'd7;
    localparam logic [BR_W-1:0] BR_A_EQ_B   = 'd8;
    localparam logic [BR_W-1:0] BR_LOOP     = 'd9;

    // program addresses
    localparam logic [UPC_W-1:0] U_IDLE = 'd0;
    localparam logic [UPC_W-1:0] U_DISP = 'd1;
    localparam logic [UPC_W-1:0] U_A0   = 'd2;
    localparam logic [UPC_W-1:0] U_A1   = 'd3;
    localparam logic [UPC_W-1:0] U_A2   = 'd4;
    localparam logic [UPC_W-1:0] U_A3   = 'd5;
    localparam logic [UPC_W-1:0] U_Q0   = 'd6;
    localparam logic [UPC_W-1:0] U_Q1   = 'd7;
    localparam logic [UPC_W-1:0] U_Q2   = 'd8;
    localparam logic [UPC_W-1:0] U_QL0  = 'd9;
    localparam logic [UPC_W-1:0] U_QL1  = 'd10;
    localparam logic [UPC_W-1:0] U_QL2  = 'd11;
    localparam logic [UPC_W-1:0] U_QL3  = 'd12;
    localparam logic [UPC_W-1:0] U_QE   = 'd13;
    localparam logic [UPC_W-1:0] U_QJ0  = 'd14;
    localparam logic [UPC_W-1:0] U_QJ1  = 'd15;
    localparam logic [UPC_W-1:0] U_QP0  = 'd16;
    localparam logic [UPC_W-1:0] U_QP1  = 'd17;
    localparam logic [UPC_W-1:0] U_EMIT = 'd18;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BR_W-1:0]  br;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic            idle;
        logic [OP_W-1:0] op;
        logic            k_dec;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic kind;
        logic a_zero;
        logic a_eq_b;
        logic lift_ok;
        logic k_zero;
        logic k_att_last;
        logic out_busy;
    } stat_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        w = '{op: OP_NOP, br: BR_JUMP, target: U_IDLE};
        case (upc)
            U_IDLE:  w = '{op: OP_LOAD,       br: BR_WAIT_IN,  target: U_IDLE};
            U_DISP:  w = '{op: OP_NOP,        br: BR_KIND_Q,   target: U_Q0};
            // attach
            U_A0:    w = '{op: OP_RD_DEP_B,   br: BR_A_ZERO,   target: U_IDLE};
            U_A1:    w = '{op: OP_ATT_BASE,   br: BR_NEXT,     target: U_IDLE};
            U_A2:    w = '{op: OP_RD_ANC,     br: BR_NEXT,     target: U_IDLE};
            U_A3:    w = '{op: OP_ATT_STEP,   br: BR_ATT_LOOP, target: U_A2};
            // query: depths and ordering
            U_Q0:    w = '{op: OP_RD_DEP_A,   br: BR_NEXT,     target: U_IDLE};
            U_Q1:    w = '{op: OP_LD_DA_RD_B, br: BR_NEXT,     target: U_IDLE};
            U_Q2:    w = '{op: OP_LD_DB_SWAP, br: BR_NEXT,     target: U_IDLE};
            // query: lift deeper node
            U_QL0:   w = '{op: OP_RD_ANC,     br: BR_NO_LIFT,  target: U_QL3};
            U_QL1:   w = '{op: OP_LIFT_A,     br: BR_NEXT,     target: U_IDLE};
            U_QL2:   w = '{op: OP_LD_DA,      br: BR_LOOP,     target: U_QL0};
            U_QL3:   w = '{op: OP_NOP,        br: BR_LOOP,     target: U_QL0};
            // query: joint lift
            U_QE:    w = '{op: OP_SET_K,      br: BR_A_EQ_B,   target: U_EMIT};
            U_QJ0:   w = '{op: OP_RD_ANC,     br: BR_NEXT,     target: U_IDLE};
            U_QJ1:   w = '{op: OP_JOINT,      br: BR_LOOP,     target: U_QJ0};
            U_QP0:   w = '{op: OP_RD_ANC,     br: BR_NEXT,     target: U_IDLE};
            U_QP1:   w = '{op: OP_LIFT_A,     br: BR_NEXT,     target: U_IDLE};
            U_EMIT:  w = '{op: OP_EMIT,       br: BR_WAIT_OUT, target: U_IDLE};
            default: w = '{op: OP_NOP,        br: BR_JUMP,     target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/bllca_ram.sv
// ----------------------------------------------------------------------------
// bllca_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module bllca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/bllca_useq.sv
// ----------------------------------------------------------------------------
// bllca_useq
// Microcode sequencer: step counter, control ROM and branch unit.
// ----------------------------------------------------------------------------
module bllca_useq import bllca_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;
    ucode_t           uw;

    assign uw      = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + UPC_W'(1);

    always_comb
    begin
        case (uw.br)
            BR_NEXT:     upc_next = upc_inc;
            BR_JUMP:     upc_next = uw.target;
            BR_WAIT_IN:  upc_next = stat.in_fire ? upc_inc : upc_reg;
            BR_WAIT_OUT: upc_next = stat.out_busy ? upc_reg : uw.target;
            BR_KIND_Q:   upc_next = stat.kind ? uw.target : upc_inc;
            BR_A_ZERO:   upc_next = stat.a_zero ? uw.target : upc_inc;
            BR_ATT_LOOP: upc_next = stat.k_att_last ? U_IDLE : uw.target;
            BR_NO_LIFT:  upc_next = stat.lift_ok ? upc_inc : uw.target;
            BR_A_EQ_B:   upc_next = stat.a_eq_b ? uw.target : upc_inc;
            BR_LOOP:     upc_next = stat.k_zero ? upc_inc : uw.target;
            default:     upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.idle  = (upc_reg == U_IDLE);
    assign ctrl.op    = uw.op;
    assign ctrl.k_dec = (uw.br == BR_LOOP) && !stat.k_zero;

endmodule

FILE: src/bllca_dpath.sv
// ----------------------------------------------------------------------------
// bllca_dpath
// Datapath: node and depth registers, level counter, ancestor table (two
// copies for two reads a cycle), depth table and the output word register.
// ----------------------------------------------------------------------------
module bllca_dpath import bllca_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_t                ctrl,
    output stat_t                stat,
    input  logic                 s_tvalid,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW         = $clog2(MAX_NODES);
    localparam int LW         = $clog2(LIFT_LEVELS);
    localparam int ANC_AW     = AW + LW;
    localparam int ANC_DEPTH  = MAX_NODES << LW;
    localparam int NODE_RANGE = 1 << NODE_W;
    localparam logic [LW-1:0] K_TOP      = LW'(LIFT_LEVELS - 1);
    localparam logic [LW-1:0] K_ATT_LAST = LW'(LIFT_LEVELS - 2);

    // id modulo MAX_NODES by restoring subtraction
    function automatic logic [NODE_W-1:0] node_reduce(input logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        r = v;
        for (int s = NODE_W - 1; s >= 0; s--)
        begin
            if ((MAX_NODES << s) < NODE_RANGE && 32'(r) >= 32'(MAX_NODES << s))
            begin
                r = r - NODE_W'(MAX_NODES << s);
            end
        end
        return r;
    endfunction

    logic                kind_reg, kind_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [DEPTH_W-1:0]  da_reg, da_next;
    logic [DEPTH_W-1:0]  db_reg, db_next;
    logic [LW-1:0]       k_reg, k_next;
    logic                dz_reg, dz_next;
    logic                az0_reg, az0_next;
    logic                az1_reg, az1_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                in_fire;
    logic                out_busy;
    logic [DEPTH_W-1:0]  diff;

    logic                dep_rd_en;
    logic [NODE_W-1:0]   dep_rd_node;
    logic                dep_wr_en;
    logic [DEPTH_W-1:0]  dep_rdata;
    logic [DEPTH_W-1:0]  dep_val;
    logic [DEPTH_W-1:0]  dep_inc;

    logic                anc_rd_en;
    logic                anc_wr_en;
    logic [LW-1:0]       anc_wr_k;
    logic [NODE_W-1:0]   anc_wr_data;
    logic [NODE_W-1:0]   anc0_rdata, anc1_rdata;
    logic [NODE_W-1:0]   anc0, anc1;

    assign in_fire  = ctrl.idle && s_tvalid;
    assign out_busy = m_tvalid_reg && !m_tready;

    // node 0 is the sentinel: all its entries read as zero
    assign dep_val = dz_reg  ? '0 : dep_rdata;
    assign anc0    = az0_reg ? '0 : anc0_rdata;
    assign anc1    = az1_reg ? '0 : anc1_rdata;
    assign dep_inc = dep_val + DEPTH_W'(1);
    assign diff    = da_reg - db_reg;

    always_comb
    begin
        dep_rd_en   = 1'b0;
        dep_rd_node = a_reg;
        dep_wr_en   = 1'b0;
        anc_rd_en   = 1'b0;
        anc_wr_en   = 1'b0;
        anc_wr_k    = '0;
        anc_wr_data = b_reg;
        case (ctrl.op)
            OP_RD_DEP_A:
            begin
                dep_rd_en = 1'b1;
            end
            OP_RD_DEP_B, OP_LD_DA_RD_B:
            begin
                dep_rd_en   = 1'b1;
                dep_rd_node = b_reg;
            end
            OP_LIFT_A:
            begin
                dep_rd_en   = 1'b1;
                dep_rd_node = anc0;
            end
            OP_ATT_BASE:
            begin
                dep_wr_en = 1'b1;
                anc_wr_en = 1'b1;
            end
            OP_ATT_STEP:
            begin
                anc_wr_en   = 1'b1;
                anc_wr_k    = k_reg + LW'(1);
                anc_wr_data = anc1;
            end
            OP_RD_ANC:
            begin
                anc_rd_en = 1'b1;
            end
            default:
            begin
                dep_rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        kind_next     = kind_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        k_next        = k_reg;
        dz_next       = dep_rd_en ? (dep_rd_node == '0) : dz_reg;
        az0_next      = anc_rd_en ? (a_reg == '0) : az0_reg;
        az1_next      = anc_rd_en ? (b_reg == '0) : az1_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    kind_next = s_tuser;
                    a_next    = node_reduce(s_tdata[NODE_W-1:0]);
                    b_next    = node_reduce(s_tdata[2*NODE_W-1:NODE_W]);
                end
            end
            OP_LD_DA_RD_B, OP_LD_DA:
            begin
                da_next = dep_val;
            end
            OP_LD_DB_SWAP:
            begin
                k_next = K_TOP;
                if (da_reg < dep_val)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = dep_val;
                    db_next = da_reg;
                end
                else
                begin
                    db_next = dep_val;
                end
            end
            OP_ATT_BASE:
            begin
                k_next = '0;
            end
            OP_ATT_STEP:
            begin
                b_next = anc1;
                k_next = k_reg + LW'(1);
            end
            OP_LIFT_A:
            begin
                a_next = anc0;
            end
            OP_SET_K:
            begin
                k_next = K_TOP;
            end
            OP_JOINT:
            begin
                if (anc0 != anc1)
                begin
                    a_next = anc0;
                    b_next = anc1;
                end
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = a_reg;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
        if (ctrl.k_dec)
        begin
            k_next = k_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        da_reg      <= da_next;
        db_reg      <= db_next;
        k_reg       <= k_next;
        dz_reg      <= dz_next;
        az0_reg     <= az0_next;
        az1_reg     <= az1_next;
        m_tdata_reg <= m_tdata_next;
    end

    bllca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .clk     (clk),
        .wr_en   (dep_wr_en),
        .wr_addr (AW'(a_reg)),
        .wr_data (dep_inc),
        .rd_en   (dep_rd_en),
        .rd_addr (AW'(dep_rd_node)),
        .rd_data (dep_rdata)
    );

    bllca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram0 (
        .clk     (clk),
        .wr_en   (anc_wr_en),
        .wr_addr ({AW'(a_reg), anc_wr_k}),
        .wr_data (anc_wr_data),
        .rd_en   (anc_rd_en),
        .rd_addr ({AW'(a_reg), k_reg}),
        .rd_data (anc0_rdata)
    );

    bllca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram1 (
        .clk     (clk),
        .wr_en   (anc_wr_en),
        .wr_addr (ANC_AW'({AW'(a_reg), anc_wr_k})),
        .wr_data (anc_wr_data),
        .rd_en   (anc_rd_en),
        .rd_addr (ANC_AW'({AW'(b_reg), k_reg})),
        .rd_data (anc1_rdata)
    );

    assign stat.in_fire    = in_fire;
    assign stat.kind       = kind_reg;
    assign stat.a_zero     = (a_reg == '0);
    assign stat.a_eq_b     = (a_reg == b_reg);
    assign stat.lift_ok    = (da_reg >= db_reg) && ((diff >> k_reg) != '0);
    assign stat.k_zero     = (k_reg == '0);
    assign stat.k_att_last = (k_reg == K_ATT_LAST);
    assign stat.out_busy   = out_busy;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_tdata_reg);

endmodule

FILE: src/binary_lifting_lca.sv
// Attach: writes depth and ancestor rows of node_a (not node 0), no result word.
// Query: one result word, ready sooner when the lifted node meets the other;
// one query in flight.
// Rate is set by the chain of dependent ancestor and depth table reads.
// Reset returns the sequencer to idle and empties the output register;
// tables are not cleared, node 0 reads as zero by address decode.
// ----------------------------------------------------------------------------
// binary_lifting_lca
// Lowest common ancestor over a binary-lifting ancestor table, driven by a
// microcoded sequencer.
// ----------------------------------------------------------------------------
module binary_lifting_lca import bllca_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // node_a[9:0], node_b[19:10], zero pad
    input  logic                 s_tuser,   // kind: 0 attach, 1 query
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // common_ancestor[9:0], zero pad
);

    ctrl_t ctrl;
    stat_t stat;

    bllca_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    bllca_dpath #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = ctrl.idle;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("accepted a word but stayed ready");

    a_emit_loads_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_EMIT && !stat.out_busy |=> m_tvalid
    ) else $error("emit step did not load output register");

    a_no_k_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.k_dec |=> !(ctrl.idle && $past(stat.k_zero))
    ) else $error("level counter decremented below zero");

endmodule
